// ----- src/pbfl_pkg.sv -----
// Shared types and constants of the presence bitmap field locator.
`default_nettype none

package pbfl_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int SLOTS_PER_BYTE = 7;
    localparam int BASE_IN_W = 48;
    localparam int QDEPTH = 4;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_OOB = 2'd2;

    // word kinds tagged by the front
    localparam logic [1:0] K_START = 2'd0;  // first header byte, carries the base
    localparam logic [1:0] K_HEADER = 2'd1; // header byte that ends the buffer
    localparam logic [1:0] K_HDR_END = 2'd2; // eighth header byte
    localparam logic [1:0] K_BODY = 2'd3;   // bitmap, table or offset byte

    typedef struct packed {
        logic [1:0]           kind;
        logic                 last;
        logic [7:0]           data;
        logic [BASE_IN_W-1:0] base;
    } item_t;

endpackage

`default_nettype wire

// ----- src/presence_bitmap_field_locator_top.sv -----
// m_tvalid is registered: a word's deciding byte goes through the queue, then the output register.
// Throughput: one input word per cycle; the back end walks one byte per cycle from a
// four-word queue, so the input stalls only when the output is held off.
// Reset (rst_n low, asynchronous): no object in progress, queue and output empty,
// target_slot cleared to 0.
`default_nettype none

module presence_bitmap_field_locator_top
    import pbfl_pkg::*;
#(
    parameter int ADDR_WIDTH = 48
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [15:0]          cfg_wr_data,  // target_slot
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [55:0]          s_tdata,      // data_byte[7:0], object_base[55:8]
    input  wire logic                 s_tuser,      // object_start
    input  wire logic                 s_tlast,      // buffer_end
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [((ADDR_WIDTH+24)/8)*8-1:0] m_tdata, // relative_offset, field_address
    output logic [1:0]                m_tuser       // status
);

    localparam int OUT_W = ((ADDR_WIDTH + 24) / 8) * 8;

    logic                push;
    item_t               push_item;
    logic                q_ready;
    logic                q_valid;
    item_t               q_head;
    logic                q_pop;
    logic [15:0]         out_rel;
    logic [ADDR_WIDTH:0] out_addr;

    pbfl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    pbfl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .ready     (q_ready),
        .valid     (q_valid),
        .head      (q_head),
        .pop       (q_pop)
    );

    pbfl_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_status  (m_tuser),
        .out_rel     (out_rel),
        .out_addr    (out_addr)
    );

    assign m_tdata = OUT_W'({out_addr, out_rel});

endmodule

`default_nettype wire

// ----- src/pbfl_front.sv -----
// Front end: accepts input words, tracks the object header and tags each word.
`default_nettype none

module pbfl_front
    import pbfl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // data_byte[7:0], object_base[55:8]
    input  wire logic        s_tuser,   // object_start
    input  wire logic        s_tlast,   // buffer_end
    output logic             push,
    output item_t            push_item,
    input  wire logic        q_ready
);

    logic       active_reg, active_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       fire;

    assign s_tready = q_ready;
    assign fire = s_tvalid && q_ready;

    always_comb
    begin
        active_next = active_reg;
        cnt_next = cnt_reg;
        push = 1'b0;
        push_item.kind = K_BODY;
        push_item.last = s_tlast;
        push_item.data = s_tdata[7:0];
        push_item.base = s_tdata[55:8];
        if (fire)
        begin
            if (s_tuser)
            begin
                active_next = 1'b1;
                cnt_next = 3'd1;
                push = 1'b1;
                push_item.kind = K_START;
            end
            else if (active_reg)
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(HEADER_BYTES - 1))
                begin
                    active_next = 1'b0;
                    push = 1'b1;
                    push_item.kind = K_HDR_END;
                end
                else if (s_tlast)
                begin
                    // header cut short by the buffer end
                    active_next = 1'b0;
                    push = 1'b1;
                    push_item.kind = K_HEADER;
                end
                // other header bytes carry nothing the back end needs
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/pbfl_queue.sv -----
// Small register FIFO between the front and back ends.
`default_nettype none

module pbfl_queue
    import pbfl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    output logic       ready,
    output logic       valid,
    output item_t      head,
    input  wire logic  pop
);

    localparam int PW = $clog2(QDEPTH);

    item_t         mem_reg [QDEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;
    logic          do_push, do_pop;

    assign ready = cnt_reg < (PW+1)'(QDEPTH);
    assign valid = cnt_reg != '0;
    assign head = mem_reg[rd_reg];
    assign do_push = push && ready;
    assign do_pop = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= rd_reg + PW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (PW+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ----- src/pbfl_back.sv -----
// Back end: walks the bitmap and offset table and registers the result word.
`default_nettype none

module pbfl_back
    import pbfl_pkg::*;
#(
    parameter int ADDR_WIDTH = 48
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [15:0]           cfg_wr_data,
    input  wire logic                  q_valid,
    input  item_t                      q_head,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [1:0]                 out_status,
    output logic [15:0]                out_rel,
    output logic [ADDR_WIDTH:0]        out_addr
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_BITMAP = 3'd2;
    localparam logic [2:0] PH_TAIL = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_OFF_LO = 3'd5;
    localparam logic [2:0] PH_OFF_HI = 3'd6;

    logic [15:0]           target_reg;
    logic [2:0]            phase_reg, phase_next;
    logic [16:0]           slot_reg, slot_next;
    logic [15:0]           present_reg, present_next;
    logic [16:0]           skip_reg, skip_next;
    logic [7:0]            lo_reg, lo_next;
    logic [ADDR_WIDTH-1:0] base_reg, base_next;

    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [15:0]           out_rel_reg;
    logic [ADDR_WIDTH:0]   out_addr_reg;

    logic                  advance;
    logic                  emit;
    logic [1:0]            emit_status;
    logic [15:0]           emit_rel;
    logic [2:0]            ph;

    // bitmap byte decode
    logic [16:0]           tgt;
    logic [16:0]           gap;
    logic                  reached;
    logic                  in_byte;
    logic [6:0]            below;
    logic [2:0]            below_cnt;
    logic [15:0]           present_upd;
    logic [16:0]           table_bytes;

    assign advance = q_valid && (!out_valid_reg || m_tready);
    assign q_pop = advance;

    assign tgt = {1'b0, target_reg};
    assign reached = slot_reg <= tgt;
    assign gap = tgt - slot_reg;
    assign in_byte = reached && (gap < 17'(SLOTS_PER_BYTE));

    always_comb
    begin
        below_cnt = 3'd0;
        for (int b = 0; b < SLOTS_PER_BYTE; b++)
        begin
            below[b] = reached && (gap > 17'(b)) && q_head.data[b];
            below_cnt = below_cnt + 3'(below[b]);
        end
    end

    assign present_upd = present_reg + 16'(below_cnt);
    assign table_bytes = {present_upd, 1'b0};

    always_comb
    begin
        phase_next = phase_reg;
        slot_next = slot_reg;
        present_next = present_reg;
        skip_next = skip_reg;
        lo_next = lo_reg;
        base_next = base_reg;
        emit = 1'b0;
        emit_status = ST_ABSENT;
        emit_rel = 16'd0;
        ph = phase_reg;
        if (advance)
        begin
            if (q_head.kind == K_START)
            begin
                ph = PH_HEADER;
                phase_next = PH_HEADER;
                base_next = ADDR_WIDTH'(q_head.base);
                slot_next = '0;
                present_next = '0;
                skip_next = '0;
                lo_next = '0;
            end
            unique case (ph)
                PH_IDLE:
                begin
                end
                PH_HEADER:
                begin
                    if (q_head.kind == K_HDR_END)
                        phase_next = PH_BITMAP;
                end
                PH_BITMAP:
                begin
                    slot_next = slot_reg + 17'(SLOTS_PER_BYTE);
                    present_next = present_upd;
                    if (in_byte && !q_head.data[gap[2:0]])
                    begin
                        emit = 1'b1;
                        emit_status = ST_ABSENT;
                    end
                    else if (in_byte)
                    begin
                        if (q_head.data[7])
                            phase_next = PH_TAIL;
                        else
                        begin
                            skip_next = table_bytes;
                            phase_next = (table_bytes == '0) ? PH_OFF_LO : PH_SKIP;
                        end
                    end
                    else if (!q_head.data[7])
                    begin
                        emit = 1'b1;
                        emit_status = ST_ABSENT;
                    end
                end
                PH_TAIL:
                begin
                    if (!q_head.data[7])
                    begin
                        skip_next = {present_reg, 1'b0};
                        phase_next = (present_reg == '0) ? PH_OFF_LO : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 17'd1;
                    if (skip_reg == 17'd1)
                        phase_next = PH_OFF_LO;
                end
                PH_OFF_LO:
                begin
                    lo_next = q_head.data;
                    phase_next = PH_OFF_HI;
                end
                PH_OFF_HI:
                begin
                    emit = 1'b1;
                    emit_status = ST_FOUND;
                    emit_rel = {q_head.data, lo_reg};
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            // buffer end leaves an unresolved object out of bounds
            if (!emit && q_head.last && ph != PH_IDLE && ph <= PH_OFF_HI)
            begin
                emit = 1'b1;
                emit_status = ST_OOB;
            end
            if (emit)
                phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 16'd0;
            phase_reg <= PH_IDLE;
            slot_reg <= '0;
            present_reg <= '0;
            skip_reg <= '0;
            lo_reg <= '0;
            base_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                target_reg <= cfg_wr_data;
            phase_reg <= phase_next;
            slot_reg <= slot_next;
            present_reg <= present_next;
            skip_reg <= skip_next;
            lo_reg <= lo_next;
            base_reg <= base_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_rel_reg <= emit_rel;
            if (emit_status == ST_FOUND)
                out_addr_reg <= (ADDR_WIDTH+1)'(base_reg) + (ADDR_WIDTH+1)'(emit_rel);
            else
                out_addr_reg <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_rel = out_rel_reg;
    assign out_addr = out_addr_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the field locator: byte streams in, located fields out.
`default_nettype none

module tb;
    import pbfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_WIDTH = 48;
    localparam int OUT_W = ((ADDR_WIDTH + 24) / 8) * 8;
    localparam int FA_W = ADDR_WIDTH + 1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_BITMAP, PH_TAIL, PH_SKIP, PH_OFF_LO, PH_OFF_HI
    } walk_phase_t;

    typedef struct {
        logic [1:0]      status;
        logic [15:0]     rel_offset;
        logic [FA_W-1:0] field_addr;
    } locate_result_t;

    typedef logic [7:0] byte_q_t[$];

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [15:0]       cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [55:0]       s_tdata = '0;   // data_byte[7:0], object_base[55:8]
    logic              s_tuser = 1'b0; // object_start
    logic              s_tlast = 1'b0; // buffer_end
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;        // relative_offset[15:0], field_address[64:16]
    logic [1:0]        m_tuser;        // status

    presence_bitmap_field_locator_top #(.ADDR_WIDTH(ADDR_WIDTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // locator state as predicted
    logic [15:0]       target_slot = '0;
    walk_phase_t       loc_phase = PH_IDLE;
    logic [2:0]        hdr_seen = '0;
    logic [16:0]       next_slot = '0;
    logic [15:0]       slots_before = '0;
    logic [16:0]       skip_left = '0;
    logic [7:0]        off_lo = '0;
    logic [47:0]       obj_base = '0;

    locate_result_t    pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int live_words = 0;
    int objects_sent = 0;
    int n_found = 0;
    int n_absent = 0;
    int n_oob = 0;

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 20)
            $display("mismatch %0d at %0t: %s got %0h want %0h", errors, $realtime, what,
                     got, want);
    endtask

    task automatic post_result(input logic [1:0] status, input logic [15:0] rel);
        locate_result_t r;
        r.status = status;
        r.rel_offset = (status == ST_FOUND) ? rel : 16'd0;
        r.field_addr = (status == ST_FOUND) ? ({1'b0, obj_base} + FA_W'(rel)) : '0;
        pending_results.push_back(r);
        loc_phase = PH_IDLE;
    endtask

    task automatic enter_table();
        skip_left = {slots_before, 1'b0};
        loc_phase = (skip_left == 0) ? PH_OFF_LO : PH_SKIP;
    endtask

    // advance the predicted locator by one accepted word
    task automatic locate_step(input logic [7:0] data, input bit start, input bit last,
                               input logic [47:0] base);
        int unsigned s;
        bit hit;
        if (start)
        begin
            obj_base = base;
            hdr_seen = '0;
            next_slot = '0;
            slots_before = '0;
            skip_left = '0;
            off_lo = '0;
            loc_phase = PH_HEADER;
        end
        case (loc_phase)
            PH_IDLE:
                return;
            PH_HEADER:
            begin
                hdr_seen = hdr_seen + 3'd1;
                if (hdr_seen == 0)
                    loc_phase = PH_BITMAP;
            end
            PH_BITMAP:
            begin
                hit = 1'b0;
                for (int b = 0; b < 7; b++)
                begin
                    s = int'(next_slot) + b;
                    if (s == int'(target_slot))
                    begin
                        if (!data[b])
                        begin
                            post_result(ST_ABSENT, 16'd0);
                            return;
                        end
                        hit = 1'b1;
                    end
                    else if (s < int'(target_slot) && data[b])
                        slots_before = slots_before + 16'd1;
                end
                next_slot = next_slot + 17'd7;
                if (hit)
                begin
                    if (data[7])
                        loc_phase = PH_TAIL;
                    else
                        enter_table();
                end
                else if (!data[7])
                begin
                    // bitmap ended below the target slot
                    post_result(ST_ABSENT, 16'd0);
                    return;
                end
            end
            PH_TAIL:
                if (!data[7])
                    enter_table();
            PH_SKIP:
            begin
                skip_left = skip_left - 17'd1;
                if (skip_left == 0)
                    loc_phase = PH_OFF_LO;
            end
            PH_OFF_LO:
            begin
                off_lo = data;
                loc_phase = PH_OFF_HI;
            end
            PH_OFF_HI:
            begin
                post_result(ST_FOUND, {data, off_lo});
                return;
            end
            default:
            begin
                loc_phase = PH_IDLE;
                return;
            end
        endcase
        if (last)
            post_result(ST_OOB, 16'd0);
    endtask

    task automatic send_word(input logic [7:0] data, input bit start, input bit last,
                             input logic [47:0] base);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {base, data};
        s_tuser <= start;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (start || loc_phase != PH_IDLE)
            live_words++;
        if (start)
            objects_sent++;
        locate_step(data, start, last, base);
    endtask

    // sender holds off until every expected result is back and the queue has emptied
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_target(input logic [15:0] value);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        target_slot = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 16'($urandom_range(16'hFFFF));
    endtask

    function automatic byte_q_t with_header(input byte_q_t body);
        byte_q_t q;
        q = {};
        repeat (8) q.push_back(8'($urandom_range(255)));
        return {q, body};
    endfunction

    // last_idx < 0: no buffer end inside the sequence
    task automatic send_seq(input logic [47:0] base, input byte_q_t q, input int last_idx);
        foreach (q[i])
            send_word(q[i], i == 0, i == last_idx, (i == 0) ? base : rand48());
    endtask

    task automatic test_found_paths();
        byte_q_t q;
        // target 0 straight into the table, zero offset and base
        send_seq(48'h0, with_header('{8'h01, 8'h00, 8'h00}), -1);
        // continued bitmap, max offset on max base; buffer end on the last offset byte
        send_seq(48'hFFFF_FFFF_FFFF, with_header('{8'h81, 8'h00, 8'hFF, 8'hFF}), 11);
        write_target(16'd9);
        q = with_header('{8'hFF, 8'h07});
        repeat (18) q.push_back(8'($urandom_range(255)));
        q.push_back(8'h34);
        q.push_back(8'h12);
        send_seq(rand48(), q, -1);
    endtask

    task automatic test_absent_paths();
        // target bit clear on the final buffer byte
        write_target(16'd0);
        send_seq(rand48(), with_header('{8'hFE}), 8);
        // bitmap stops short of the target
        write_target(16'd9);
        send_seq(rand48(), with_header('{8'h7F}), -1);
    endtask

    task automatic test_early_buffer_end();
        byte_q_t q;
        send_seq(rand48(), with_header('{8'hFF, 8'h07}), 3);
        q = with_header('{8'hFF, 8'h07});
        repeat (18) q.push_back(8'($urandom_range(255)));
        q.push_back(8'h99);
        send_seq(rand48(), q, 15);
        send_seq(rand48(), q, 28);
        write_target(16'd0);
        // target found but bitmap continues when the buffer ends
        send_seq(rand48(), with_header('{8'h81}), 8);
    endtask

    task automatic test_restart_and_idle_bytes();
        byte_q_t q;
        // stray words while idle, one marked as buffer end
        send_word(8'hA5, 1'b0, 1'b0, rand48());
        send_word(8'h5A, 1'b0, 1'b1, rand48());
        // half an object, then a fresh start abandons it
        send_seq(rand48(), with_header('{8'h81}), -1);
        send_seq(rand48(), with_header('{8'h01, 8'hCD, 8'hAB}), -1);
    endtask

    task automatic test_config_extremes();
        write_target(16'hAAAA);
        send_seq(rand48(), with_header('{8'h55}), -1);
        write_target(16'h5555);
        send_seq(rand48(), with_header('{8'hFF, 8'hFF}), 9);
    endtask

    // slot 65535: a bitmap that stops short, then one cut off by the buffer end
    task automatic test_widest_target();
        write_target(16'hFFFF);
        send_seq(48'hFFFF_FFFF_FFFF, with_header('{8'hFF, 8'hFF, 8'h7F}), -1);
        send_seq(48'hFFFF_FFFF_FFFF, with_header('{8'hFF, 8'h80}), 9);
        settle();
    endtask

    // mostly well-formed objects for the current target, some broken or cut short
    task automatic send_object(input int dens, input bit noisy);
        logic [47:0] base;
        logic [7:0]  b;
        int          tbyte;
        int          guard;
        base = rand48();
        for (int k = 0; k < 8; k++)
            send_word(8'($urandom_range(255)), k == 0, noisy && ($urandom_range(99) < 3),
                      (k == 0) ? base : rand48());
        tbyte = int'(target_slot) / 7;
        for (int k = 0; k <= tbyte; k++)
        begin
            if (loc_phase == PH_IDLE)
                return;
            for (int i = 0; i < 7; i++)
                b[i] = ($urandom_range(99) < dens);
            if (k == tbyte)
            begin
                b[int'(target_slot) % 7] = ($urandom_range(99) < 80);
                b[7] = 1'($urandom_range(1));
            end
            else
                b[7] = !(noisy && $urandom_range(99) < 5);
            send_word(b, 1'b0, noisy && ($urandom_range(99) < 3), rand48());
        end
        guard = 0;
        while (loc_phase != PH_IDLE && guard < 300)
        begin
            if (noisy && $urandom_range(99) < 3)
                return;
            send_word(8'($urandom_range(255)), 1'b0, noisy && ($urandom_range(99) < 3),
                      rand48());
            guard++;
        end
    endtask

    task automatic test_random_objects(input int budget);
        int first;
        int n;
        int r;
        first = live_words;
        n = 0;
        while (live_words - first < budget)
        begin
            if (n % 6 == 0)
            begin
                r = $urandom_range(99);
                write_target((r < 70) ? 16'($urandom_range(20)) : 16'($urandom_range(21, 60)));
            end
            if ($urandom_range(99) < 5)
                send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), rand48());
            send_object($urandom_range(10, 90), $urandom_range(99) < 25);
            n++;
        end
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_results
        locate_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none pending, status", 64'(m_tuser), 64'(0));
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[15:0] !== want.rel_offset)
                    report_mismatch("relative_offset", 64'(m_tdata[15:0]),
                                    64'(want.rel_offset));
                if (m_tdata[16 +: FA_W] !== want.field_addr)
                    report_mismatch("field_address", 64'(m_tdata[16 +: FA_W]),
                                    64'(want.field_addr));
                case (want.status)
                    ST_FOUND:  n_found++;
                    ST_ABSENT: n_absent++;
                    default:   n_oob++;
                endcase
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_stall_pct = 77;
        test_found_paths();
        test_absent_paths();
        test_early_buffer_end();
        test_restart_and_idle_bytes();
        test_config_extremes();
        test_random_objects(60);

        send_idle_pct = 77;
        recv_stall_pct = 33;
        test_random_objects(60);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_objects(60);
        test_widest_target();

        $display("covered %0d objects over %0d live bytes, with stalls on both sides",
                 objects_sent, live_words);
        $display("results: %0d found, %0d absent, %0d out of bounds; %0d mismatches",
                 n_found, n_absent, n_oob, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- presence_bitmap_field_locator_top.f -----
src/pbfl_pkg.sv
src/pbfl_front.sv
src/pbfl_queue.sv
src/pbfl_back.sv
src/presence_bitmap_field_locator_top.sv
tb/tb.sv
